// ----- sv/qyaw_pkg.sv -----
`default_nettype none
package qyaw_pkg;

  localparam int IN_W         = 16;
  localparam int OUT_W        = 16;
  localparam int PROD_W       = 32;
  // num = 2(xz - wy) stays below 2^32 in magnitude, den = 2^30 - 2(y^2 + z^2) reaches -3 * 2^30
  localparam int OPER_W       = 34;
  // vector magnitude stays below 2^34 after the CORDIC gain
  localparam int VEC_W        = 37;
  localparam int ATAN_ENTRIES = 24;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_BITS_DEF   = 16;

  // atan(2^-i), 2^32 counts per full turn
  localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic valid;
    logic zero;
  } qyaw_ctl_t;

  // table entry rounded half up to angle_bits per turn
  function automatic logic [31:0] atan_entry(input int idx, input int angle_bits);
    logic [32:0] sum;
    int          sh;
    sh  = 32 - angle_bits;
    sum = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (sh - 1));
    return 32'(sum >> sh);
  endfunction

endpackage
`default_nettype wire

// ----- sv/qyaw_prep.sv -----
`default_nettype none
module qyaw_prep import qyaw_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic signed [IN_W-1:0]       quat_w,
  input  wire logic signed [IN_W-1:0]       quat_x,
  input  wire logic signed [IN_W-1:0]       quat_y,
  input  wire logic signed [IN_W-1:0]       quat_z,
  output qyaw_ctl_t                         ctl_out,
  output logic signed [VEC_W-1:0]           vx,
  output logic signed [VEC_W-1:0]           vy,
  output logic        [ANGLE_BITS-1:0]      acc
);

  localparam logic signed [OPER_W-1:0] ONE_Q30 = OPER_W'(64'sd1 << 30);
  localparam logic [ANGLE_BITS-1:0]    HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  // stage 1: products
  logic                     v1;
  logic signed [PROD_W-1:0] xz, wy, yy, zz;
  // stage 2: operands
  logic                     v2;
  logic signed [OPER_W-1:0] num, den;

  logic signed [OPER_W-1:0] diff_next, sq_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    xz <= quat_x * quat_z;
    wy <= quat_w * quat_y;
    yy <= quat_y * quat_y;
    zz <= quat_z * quat_z;
  end

  always_comb begin
    diff_next = OPER_W'(xz) - OPER_W'(wy);
    sq_next   = OPER_W'(yy) + OPER_W'(zz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    num <= diff_next <<< 1;
    den <= ONE_Q30 - (sq_next <<< 1);
  end

  // stage 3: fold the left half plane over by half a turn
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= v2;
    end
    ctl_out.zero <= (num == '0) && (den == '0);
    if (den < 0) begin
      vx  <= -VEC_W'(den);
      vy  <= -VEC_W'(num);
      acc <= HALF_TURN;
    end else begin
      vx  <= VEC_W'(den);
      vy  <= VEC_W'(num);
      acc <= '0;
    end
  end

`ifndef ASSERT_OFF
  a_vx_nonneg: assert property (@(posedge clk) disable iff (rst)
    ctl_out.valid |-> !vx[VEC_W-1])
    else $error("qyaw_prep: start vector in left half plane");
  a_zero_vec: assert property (@(posedge clk) disable iff (rst)
    (ctl_out.valid && ctl_out.zero) |-> (vx == '0 && vy == '0))
    else $error("qyaw_prep: zero flag on nonzero vector");
`endif

endmodule
`default_nettype wire

// ----- sv/qyaw_cordic_stage.sv -----
`default_nettype none
module qyaw_cordic_stage import qyaw_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int IDX        = 0
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire qyaw_ctl_t                    ctl_in,
  input  wire logic signed [VEC_W-1:0]      vx_in,
  input  wire logic signed [VEC_W-1:0]      vy_in,
  input  wire logic        [ANGLE_BITS-1:0] acc_in,
  output qyaw_ctl_t                         ctl_out,
  output logic signed [VEC_W-1:0]           vx_out,
  output logic signed [VEC_W-1:0]           vy_out,
  output logic        [ANGLE_BITS-1:0]      acc_out
);

  localparam logic [ANGLE_BITS-1:0] STEP_ANGLE = ANGLE_BITS'(atan_entry(IDX, ANGLE_BITS));

  logic signed [VEC_W-1:0] dx, dy;

  always_comb begin
    dx = vy_in >>> IDX;
    dy = vx_in >>> IDX;
  end

  // rotate toward the x axis
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.zero <= ctl_in.zero;
    if (vy_in[VEC_W-1]) begin
      vx_out  <= vx_in - dx;
      vy_out  <= vy_in + dy;
      acc_out <= acc_in - STEP_ANGLE;
    end else begin
      vx_out  <= vx_in + dx;
      vy_out  <= vy_in - dy;
      acc_out <= acc_in + STEP_ANGLE;
    end
  end

`ifndef ASSERT_OFF
  a_valid_moves: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (ctl_out.valid == $past(ctl_in.valid)))
    else $error("qyaw_cordic_stage: valid bit lost or invented");
`endif

endmodule
`default_nettype wire

// ----- sv/qyaw_round.sv -----
`default_nettype none
module qyaw_round import qyaw_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire qyaw_ctl_t               ctl_in,
  input  wire logic [ANGLE_BITS-1:0]   acc_in,
  output logic                         done,
  output logic [OUT_W-1:0]             yaw_angle
);

  logic [OUT_W-1:0] yaw_next;

  generate
    if (ANGLE_BITS > OUT_W) begin : g_narrow
      localparam int SH = ANGLE_BITS - OUT_W;
      logic [ANGLE_BITS-1:0] sum;
      // round half up, wrap modulo a full turn
      always_comb begin
        sum      = acc_in + (ANGLE_BITS'(1) << (SH - 1));
        yaw_next = sum[ANGLE_BITS-1:SH];
      end
    end else if (ANGLE_BITS == OUT_W) begin : g_same
      always_comb yaw_next = OUT_W'(acc_in);
    end else begin : g_widen
      always_comb yaw_next = {acc_in, {(OUT_W - ANGLE_BITS){1'b0}}};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.valid;
    end
    yaw_angle <= ctl_in.zero ? '0 : yaw_next;
  end

endmodule
`default_nettype wire

// ----- sv/quaternion_mount_yaw_extract_unit.sv -----
`default_nettype none
// From start to done an item passes the prep registers (products, operands, folded
//   start vector), then the CORDIC stages, then the rounding register.
// Throughput: one quaternion every cycle; busy stays low, each CORDIC step has its
//   own stage.
// Reset: synchronous rst clears all valid bits; items in flight are dropped.
// The receiver cannot stall: yaw_angle is valid only in the cycle done is high.
module quaternion_mount_yaw_extract_unit import qyaw_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic signed [IN_W-1:0] quat_w,
  input  wire logic signed [IN_W-1:0] quat_x,
  input  wire logic signed [IN_W-1:0] quat_y,
  input  wire logic signed [IN_W-1:0] quat_z,
  output logic                        done,
  output logic [OUT_W-1:0]            yaw_angle
);

  // steps beyond the arctangent table would add nothing
  localparam int NSTEPS  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int LATENCY = NSTEPS + 4;

  // the pipeline never holds off an item
  assign busy = 1'b0;

  // per-stage signals of the CORDIC chain; index 0 is the prep output
  qyaw_ctl_t               ctl_s [NSTEPS+1];
  logic signed [VEC_W-1:0] vx_s  [NSTEPS+1];
  logic signed [VEC_W-1:0] vy_s  [NSTEPS+1];
  logic [ANGLE_BITS-1:0]   acc_s [NSTEPS+1];

  // mount correction folds into num = 2(xz - wy), den = 1 - 2(y^2 + z^2);
  // the prep also turns a left half plane vector by half a turn
  qyaw_prep #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .quat_w   (quat_w),
    .quat_x   (quat_x),
    .quat_y   (quat_y),
    .quat_z   (quat_z),
    .ctl_out  (ctl_s[0]),
    .vx       (vx_s[0]),
    .vy       (vy_s[0]),
    .acc      (acc_s[0])
  );

  // vectoring CORDIC: one micro-rotation per stage
  generate
    for (genvar i = 0; i < NSTEPS; i++) begin : g_step
      qyaw_cordic_stage #(
        .ANGLE_BITS (ANGLE_BITS),
        .IDX        (i)
      ) u_stage (
        .clk     (clk),
        .rst     (rst),
        .ctl_in  (ctl_s[i]),
        .vx_in   (vx_s[i]),
        .vy_in   (vy_s[i]),
        .acc_in  (acc_s[i]),
        .ctl_out (ctl_s[i+1]),
        .vx_out  (vx_s[i+1]),
        .vy_out  (vy_s[i+1]),
        .acc_out (acc_s[i+1])
      );
    end
  endgenerate

  // scale the angle to 16 bits (rounding when narrowing), force zero vectors to 0
  qyaw_round #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_round (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (ctl_s[NSTEPS]),
    .acc_in    (acc_s[NSTEPS]),
    .done      (done),
    .yaw_angle (yaw_angle)
  );

`ifndef ASSERT_OFF
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, LATENCY))
    else $error("quaternion_mount_yaw_extract_unit: result without an item");
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("quaternion_mount_yaw_extract_unit: pipeline held off an item");
`endif

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

// Checks the mounting-corrected yaw extractor: every accepted quaternion is
// run through a local fixed-point model (exact mounting fold, vectoring
// CORDIC, binary-angle rounding) and the expected yaw is queued. Each done
// strobe is compared with the oldest queued yaw. The stimulus runs a short
// directed part (field extremes, quadrant corners, zero vector, wrap near
// 360 degrees), a drain pause, then random quaternions, half of them unit length,
// under three idling profiles on the sender side.
module tb;
  import qyaw_pkg::*;

  localparam int STEPS      = CORDIC_STEPS_DEF;
  localparam int ANG_BITS   = ANGLE_BITS_DEF;
  localparam int LATENCY    = STEPS + 4;
  localparam int SHOW_FAILS = 10;

  typedef logic signed [IN_W-1:0] comp_t;

  // one accepted quaternion and the yaw it must produce
  typedef struct {
    comp_t            w;
    comp_t            x;
    comp_t            y;
    comp_t            z;
    logic [OUT_W-1:0] yaw;
  } quat_job_t;

  // shapes of random quaternions
  typedef enum int {
    QMIX_UNIT,
    QMIX_RAW,
    QMIX_EDGE
  } quat_mix_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  comp_t            quat_w = '0;
  comp_t            quat_x = '0;
  comp_t            quat_y = '0;
  comp_t            quat_z = '0;
  logic             busy;
  logic             done;
  logic [OUT_W-1:0] yaw_angle;

  quat_job_t yaw_due[$];   // yaws still owed by the block, oldest first
  int        yaw_faults = 0;
  int        gap_pct    = 0;  // chance, in percent, that the sender idles a cycle

  quaternion_mount_yaw_extract_unit #(
    .CORDIC_STEPS (STEPS),
    .ANGLE_BITS   (ANG_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z),
    .done      (done),
    .yaw_angle (yaw_angle)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest correct run (about 700 items, each with
  // sender gaps, plus drain pauses).
  initial begin
    #4_800_000;
    $display("TB_ERROR");
    $finish;
  end

  // Yaw of the mount-corrected quaternion. The mounting product folds exactly:
  // num = 2(xz - wy), den = 2^30 - 2(y^2 + z^2), both in Q.30 units.
  function automatic logic [OUT_W-1:0] predict_yaw(input comp_t w, input comp_t x,
                                                   input comp_t y, input comp_t z);
    longint          num;
    longint          den;
    longint          vx;
    longint          vy;
    longint          dx;
    longint          dy;
    longint unsigned turn;
    longint unsigned wide;
    logic [31:0]     acc;
    logic [31:0]     step_ang;
    logic [31:0]     mask;
    int              sh;

    num  = 2 * (longint'(x) * longint'(z) - longint'(w) * longint'(y));
    den  = (longint'(1) <<< 30) - 2 * (longint'(y) * longint'(y) + longint'(z) * longint'(z));
    mask = 32'((64'd1 << ANG_BITS) - 64'd1);
    acc  = '0;
    vx   = den;
    vy   = num;

    // zero vector: no direction, report 0
    if (num == 0 && den == 0) begin
      return '0;
    end

    // left half-plane: turn by half a turn first so the CORDIC converges
    if (vx < 0) begin
      vx  = -vx;
      vy  = -vy;
      acc = 32'd1 << (ANG_BITS - 1);
    end

    sh = 32 - ANG_BITS;
    for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
      // >>> on a signed longint floors, matching the hardware shifters
      dx       = vy >>> i;
      dy       = vx >>> i;
      turn     = ATAN_TURN32[i];
      step_ang = 32'((turn + (64'd1 << (sh - 1))) >> sh);
      if (vy < 0) begin
        vx  = vx - dx;
        vy  = vy + dy;
        acc = acc - step_ang;
      end else begin
        vx  = vx + dx;
        vy  = vy - dy;
        acc = acc + step_ang;
      end
    end
    acc = acc & mask;

    // scale the accumulator to 16 bits; a full turn wraps to 0
    if (ANG_BITS > 16) begin
      sh   = ANG_BITS - 16;
      wide = (64'(acc) + (64'd1 << (sh - 1))) >> sh;
    end else begin
      sh   = 16 - ANG_BITS;
      wide = 64'(acc) << sh;
    end
    return wide[OUT_W-1:0];
  endfunction

  // Present one quaternion and hold it until the block takes it. Start is left
  // high on return; the next call or quiesce_sender decides its next value, so
  // start never gets two assignments in one time step.
  task automatic send_quat(input comp_t w, input comp_t x, input comp_t y, input comp_t z);
    quat_job_t job;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    quat_w <= w;
    quat_x <= x;
    quat_y <= y;
    quat_z <= z;
    // busy read here is the value from before the edge, the one that decides
    do @(posedge clk); while (busy);
    job.w   = w;
    job.x   = x;
    job.y   = y;
    job.z   = z;
    job.yaw = predict_yaw(w, x, y, z);
    yaw_due.push_back(job);
  endtask

  // Drop start and hold until every owed yaw has come back.
  task automatic quiesce_sender();
    start <= 1'b0;
    while (yaw_due.size() != 0) @(posedge clk);
  endtask

  // Compare each strobed yaw with the oldest owed one.
  always @(posedge clk) begin
    quat_job_t job;
    if (!rst && done) begin
      if (yaw_due.size() == 0) begin
        yaw_faults++;
        if (yaw_faults <= SHOW_FAILS) begin
          $display("%0t: unexpected yaw_angle %0d with nothing outstanding", $realtime,
                   yaw_angle);
        end
      end else begin
        job = yaw_due.pop_front();
        if (yaw_angle !== job.yaw) begin
          yaw_faults++;
          if (yaw_faults <= SHOW_FAILS) begin
            $display("%0t: q=(%0d,%0d,%0d,%0d) yaw_angle expected %0d got %0d", $realtime,
                     job.w, job.x, job.y, job.z, job.yaw, yaw_angle);
          end
        end
      end
    end
  end

  // Extremes of every field, in sign patterns and, for w, y and z, alone.
  task automatic test_field_extremes();
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
    send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
    send_quat(-16'sd32768, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, -16'sd32768, 16'sd0, -16'sd32768);
    send_quat(16'sd0, 16'sd0, -16'sd32768, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd32768);
    send_quat(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
  endtask

  // Identity, quadrant axes, the zero vector, the half-turn flip and both
  // sides of the wrap at 0 / 360 degrees.
  task automatic test_special_angles();
    send_quat(16'sd32767, 16'sd0, 16'sd0, 16'sd0);           // level: 0 degrees
    send_quat(16'sd0, 16'sd16384, 16'sd16384, 16'sd16384);   // den zero, num up: 90
    send_quat(16'sd0, 16'sd0, 16'sd32767, 16'sd0);           // den negative, num 0: 180
    send_quat(16'sd0, -16'sd16384, 16'sd16384, 16'sd16384);  // den zero, num down: 270
    send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd16384);       // zero vector
    send_quat(16'sd5000, 16'sd5000, 16'sd16384, 16'sd16384); // zero vector, w = x
    send_quat(16'sd0, -16'sd1, 16'sd0, 16'sd1);              // just below 360
    send_quat(16'sd0, 16'sd1, 16'sd0, 16'sd1);               // just above 0
    send_quat(16'sd0, -16'sd1, 16'sd32767, 16'sd1);          // just past 180
    send_quat(16'sd0, 16'sd1, 16'sd32767, 16'sd1);           // just short of 180
    send_quat(16'sd23170, -16'sd23170, 16'sd0, 16'sd0);      // mounting inverse
  endtask

  // Send a burst, then hold the sender until the pipeline has drained.
  task automatic test_drain_pause();
    repeat (2) begin
      repeat (6) send_quat(comp_t'($urandom), comp_t'($urandom), comp_t'($urandom),
                           comp_t'($urandom));
      quiesce_sender();
    end
  endtask

  function automatic comp_t edge_value();
    case ($urandom_range(7))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return 16'sd0;
      3:       return -16'sd1;
      4:       return 16'sd1;
      5:       return 16'sd16384;
      6:       return -16'sd16384;
      default: return comp_t'($urandom);
    endcase
  endfunction

  // Random quaternions: half unit length as an IMU gives, the rest raw
  // full-range values or built from edge values.
  task automatic test_random_stream(input int count, input int idle_pct);
    real       c[4];
    real       norm;
    quat_mix_t mix;
    comp_t     q[4];
    gap_pct = idle_pct;
    repeat (count) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: mix = QMIX_UNIT;
        5, 6, 7:       mix = QMIX_RAW;
        default:       mix = QMIX_EDGE;
      endcase
      case (mix)
        QMIX_UNIT: begin
          norm = 0.0;
          for (int k = 0; k < 4; k++) begin
            c[k] = $itor($urandom_range(65535)) / 32767.5 - 1.0;
            norm = norm + c[k] * c[k];
          end
          norm = $sqrt(norm);
          if (norm < 1.0e-3) begin
            c[0] = 1.0;
            c[1] = 0.0;
            c[2] = 0.0;
            c[3] = 0.0;
            norm = 1.0;
          end
          for (int k = 0; k < 4; k++) q[k] = comp_t'($rtoi(c[k] / norm * 32767.0));
        end
        QMIX_RAW: begin
          for (int k = 0; k < 4; k++) q[k] = comp_t'($urandom);
        end
        default: begin
          for (int k = 0; k < 4; k++) q[k] = edge_value();
        end
      endcase
      send_quat(q[0], q[1], q[2], q[3]);
    end
  endtask

  initial begin
    // hold reset, then release it once for good
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_pct = 36;
    test_field_extremes();
    test_special_angles();
    test_drain_pause();
    test_random_stream(220, 36);
    test_random_stream(220, 50);
    test_random_stream(210, 0);

    // drain, then keep watching for stray strobes
    quiesce_sender();
    repeat (LATENCY + 8) @(posedge clk);

    if (yaw_faults == 0 && yaw_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- quaternion_mount_yaw_extract_unit.f -----
sv/qyaw_pkg.sv
sv/qyaw_prep.sv
sv/qyaw_cordic_stage.sv
sv/qyaw_round.sv
sv/quaternion_mount_yaw_extract_unit.sv
tb/tb.sv
